[design/mgi_pkg.sv]
// Shared types and constants for the multilinear grid interpolator.
package mgi_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int MAX_POINTS = 8;
    localparam int MAX_ITEMS  = 16;
    localparam int NODE_BITS  = 3;
    localparam int ITEM_BITS  = 4;
    localparam int FRAC_BITS  = 16;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [1:0] ACT_GRID  = 2'd0;
    localparam logic [1:0] ACT_TABLE = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [2:0] REG_DIMS  = 3'd0;
    localparam logic [2:0] REG_ITEMS = 3'd1;
    localparam logic [2:0] REG_PTS0  = 3'd2;
    localparam logic [2:0] REG_PTS1  = 3'd3;
    localparam logic [2:0] REG_PTS2  = 3'd4;
    localparam logic [2:0] REG_PTS3  = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIM,
        ST_LAST,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FETCH_RD,
        ST_FETCH_WR,
        ST_BL_RD,
        ST_BL_MUL1,
        ST_BL_MUL2,
        ST_BL_WR,
        ST_OUT_RD,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } state_t;

endpackage

[design/mgi_div.sv]
// Restoring divider: 16-bit fraction quotient of num/den, num < den, one bit a cycle.
module mgi_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] num,
    input  logic [32:0] den,
    output logic        done,
    output logic [15:0] quot
);
    import mgi_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] den_reg, den_next;
    logic [15:0] quot_reg, quot_next;
    logic [33:0] shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        shifted   = {rem_reg[32:0], 1'b0};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'(FRAC_BITS);
            rem_next  = {1'b0, num};
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next  = shifted - {1'b0, den_reg};
                quot_next = {quot_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                quot_next = {quot_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[design/multilinear_grid_interpolator_core.sv]
// Top level of the multilinear grid interpolator.
// Input channel (in_valid/in_stall) carries three transaction kinds: a grid
// point write, a table value write and a query. A query holds in_stall high
// until its last result has been taken.
// Per query, for each dimension: a compare against the last grid point, a bracket
// search that scans grid memory, and a division in the shared restoring divider
// when the coordinate falls inside the grid. Then the corner values are fetched
// from the node table (2^ndim * item_count values), blended on the shared 32x18
// multiplier ((2^ndim - 1) * item_count blends), and the results are sent out.
// Output channel (out_valid/out_stall) gives item_count results per query,
// last_item on the final one; a stalled result holds until taken.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written by the user only while
// idle, which the block does not enforce; values out of range saturate when a query starts.
// Reset restores the register defaults and returns to idle; grid and table
// memories are not cleared and must be written before use.
module multilinear_grid_interpolator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [1:0]  dim,
    input  logic [2:0]  point_index,
    input  logic [15:0] table_address,
    input  logic signed [31:0] write_value,
    input  logic signed [31:0] coord_0,
    input  logic signed [31:0] coord_1,
    input  logic signed [31:0] coord_2,
    input  logic signed [31:0] coord_3,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  item_index,
    output logic signed [31:0] result_value,
    output logic        last_item,
    output logic        out_of_range
);
    import mgi_pkg::*;

    // configuration
    logic [2:0] dims_cfg_reg;
    logic [4:0] items_cfg_reg;
    logic [3:0] pts_cfg_reg [MAX_DIMS];

    // memories
    logic signed [31:0] grid_mem   [MAX_DIMS*MAX_POINTS];
    logic signed [31:0] node_mem   [65536];
    logic signed [31:0] corner_mem [256];
    logic signed [31:0] g_rd, n_rd, c_rd;
    logic [4:0]  g_raddr;
    logic [15:0] n_raddr;
    logic [7:0]  c_raddr, c_waddr;
    logic        c_we;
    logic signed [31:0] c_wdata;

    state_t state_reg, state_next;
    logic [2:0]  d_reg, d_next;
    logic [3:0]  i_reg, i_next;
    logic [4:0]  c_reg, c_next;
    logic [4:0]  k_reg, k_next;
    logic [3:0]  half_reg, half_next;
    logic [2:0]  ndim_reg, ndim_next;
    logic [4:0]  nitems_reg, nitems_next;
    logic [3:0]  npts_reg [MAX_DIMS];
    logic [3:0]  npts_next [MAX_DIMS];
    logic signed [31:0] coord_reg [MAX_DIMS];
    logic signed [31:0] coord_next [MAX_DIMS];
    logic [2:0]  lower_reg [MAX_DIMS];
    logic [2:0]  lower_next [MAX_DIMS];
    logic [16:0] factor_reg [MAX_DIMS];
    logic [16:0] factor_next [MAX_DIMS];
    logic        flag_reg, flag_next;
    logic signed [31:0] gprev_reg, gprev_next;
    logic [32:0] num_reg, num_next, den_reg, den_next;
    logic signed [49:0] prod_reg, prod_next, acc_reg, acc_next;

    logic        out_valid_reg, out_valid_next;
    logic [3:0]  item_index_reg, item_index_next;
    logic signed [31:0] result_reg, result_next;
    logic        last_reg, last_next;
    logic        oor_reg, oor_next;

    logic        div_start, div_done;
    logic [15:0] div_quot;

    logic signed [31:0] mul_a;
    logic [16:0] mul_b;
    logic signed [17:0] mul_bs;
    logic signed [49:0] mul_p;

    logic        accept, adv;
    logic [1:0]  dl;
    logic signed [31:0] x_cur;
    logic [3:0]  n_cur;
    logic [4:0]  corners;
    logic [2:0]  idx [MAX_DIMS];
    logic [3:0]  csh;
    logic signed [49:0] bsum;

    mgi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    assign mul_bs = $signed({1'b0, mul_b});
    assign mul_p  = mul_a * mul_bs;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_cfg_reg  <= 3'd1;
            items_cfg_reg <= 5'd1;
            for (int j = 0; j < MAX_DIMS; j++)
                pts_cfg_reg[j] <= 4'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIMS:  dims_cfg_reg   <= cfg_data[2:0];
                REG_ITEMS: items_cfg_reg  <= cfg_data;
                REG_PTS0:  pts_cfg_reg[0] <= cfg_data[3:0];
                REG_PTS1:  pts_cfg_reg[1] <= cfg_data[3:0];
                REG_PTS2:  pts_cfg_reg[2] <= cfg_data[3:0];
                REG_PTS3:  pts_cfg_reg[3] <= cfg_data[3:0];
                default:   ;
            endcase
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (accept && action == ACT_GRID)
            grid_mem[{dim, point_index}] <= write_value;
        g_rd <= grid_mem[g_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && action == ACT_TABLE)
            node_mem[table_address] <= write_value;
        n_rd <= node_mem[n_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
            corner_mem[c_waddr] <= c_wdata;
        c_rd <= corner_mem[c_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg          <= d_next;
        i_reg          <= i_next;
        c_reg          <= c_next;
        k_reg          <= k_next;
        half_reg       <= half_next;
        ndim_reg       <= ndim_next;
        nitems_reg     <= nitems_next;
        flag_reg       <= flag_next;
        gprev_reg      <= gprev_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        item_index_reg <= item_index_next;
        result_reg     <= result_next;
        last_reg       <= last_next;
        oor_reg        <= oor_next;
        for (int j = 0; j < MAX_DIMS; j++)
        begin
            npts_reg[j]   <= npts_next[j];
            coord_reg[j]  <= coord_next[j];
            lower_reg[j]  <= lower_next[j];
            factor_reg[j] <= factor_next[j];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        d_next          = d_reg;
        i_next          = i_reg;
        c_next          = c_reg;
        k_next          = k_reg;
        half_next       = half_reg;
        ndim_next       = ndim_reg;
        nitems_next     = nitems_reg;
        flag_next       = flag_reg;
        gprev_next      = gprev_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        item_index_next = item_index_reg;
        result_next     = result_reg;
        last_next       = last_reg;
        oor_next        = oor_reg;
        for (int j = 0; j < MAX_DIMS; j++)
        begin
            npts_next[j]   = npts_reg[j];
            coord_next[j]  = coord_reg[j];
            lower_next[j]  = lower_reg[j];
            factor_next[j] = factor_reg[j];
        end
        g_raddr   = '0;
        n_raddr   = '0;
        c_raddr   = '0;
        c_we      = 1'b0;
        c_waddr   = {c_reg[3:0], k_reg[3:0]};
        c_wdata   = n_rd;
        div_start = 1'b0;
        mul_a     = c_rd;
        mul_b     = '0;
        adv       = 1'b0;

        dl      = d_reg[1:0];
        x_cur   = coord_reg[dl];
        n_cur   = npts_reg[dl];
        corners = 5'd1 << ndim_reg;
        bsum    = acc_reg + prod_reg;

        // corner node indices: bit of c per used dimension, dimension 0 highest
        for (int dd = 0; dd < MAX_DIMS; dd++)
        begin
            csh = c_reg[3:0] >> (ndim_reg - 3'(dd) - 3'd1);
            if (3'(dd) < ndim_reg)
                idx[dd] = lower_reg[dd] + {2'b0, csh[0]};
            else
                idx[dd] = lower_reg[dd];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && action == ACT_QUERY)
                begin
                    ndim_next = (dims_cfg_reg > 3'(MAX_DIMS)) ? 3'(MAX_DIMS) : dims_cfg_reg;
                    if (items_cfg_reg == 5'd0)
                        nitems_next = 5'd1;
                    else if (items_cfg_reg > 5'(MAX_ITEMS))
                        nitems_next = 5'(MAX_ITEMS);
                    else
                        nitems_next = items_cfg_reg;
                    for (int j = 0; j < MAX_DIMS; j++)
                    begin
                        if (pts_cfg_reg[j] < 4'd2)
                            npts_next[j] = 4'd2;
                        else if (pts_cfg_reg[j] > 4'(MAX_POINTS))
                            npts_next[j] = 4'(MAX_POINTS);
                        else
                            npts_next[j] = pts_cfg_reg[j];
                        lower_next[j]  = '0;
                        factor_next[j] = '0;
                    end
                    coord_next[0] = coord_0;
                    coord_next[1] = coord_1;
                    coord_next[2] = coord_2;
                    coord_next[3] = coord_3;
                    flag_next = 1'b0;
                    d_next    = '0;
                    c_next    = '0;
                    k_next    = '0;
                    if (dims_cfg_reg == 3'd0)
                        state_next = ST_FETCH_RD;
                    else
                        state_next = ST_DIM;
                end
            end
            ST_DIM:
            begin
                g_raddr    = {dl, 3'(n_cur - 4'd1)};
                state_next = ST_LAST;
            end
            ST_LAST:
            begin
                if (x_cur == g_rd)
                begin
                    lower_next[dl]  = 3'(n_cur - 4'd2);
                    factor_next[dl] = ONE_Q16;
                    adv = 1'b1;
                end
                else
                begin
                    i_next     = '0;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                g_raddr    = {dl, i_reg[2:0]};
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (g_rd > x_cur)
                begin
                    if (i_reg == 4'd0)
                    begin
                        lower_next[dl]  = '0;
                        factor_next[dl] = '0;
                        flag_next = 1'b1;
                        adv = 1'b1;
                    end
                    else
                    begin
                        num_next = 33'(33'(x_cur) - 33'(gprev_reg));
                        den_next = 33'(33'(g_rd) - 33'(gprev_reg));
                        lower_next[dl] = 3'(i_reg - 4'd1);
                        state_next = ST_DIV_GO;
                    end
                end
                else
                begin
                    gprev_next = g_rd;
                    if (i_reg + 4'd1 == n_cur)
                    begin
                        lower_next[dl]  = 3'(n_cur - 4'd2);
                        factor_next[dl] = ONE_Q16;
                        flag_next = 1'b1;
                        adv = 1'b1;
                    end
                    else
                    begin
                        i_next     = i_reg + 4'd1;
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    factor_next[dl] = {1'b0, div_quot};
                    adv = 1'b1;
                end
            end
            ST_FETCH_RD:
            begin
                n_raddr    = {idx[0], idx[1], idx[2], idx[3], k_reg[3:0]};
                state_next = ST_FETCH_WR;
            end
            ST_FETCH_WR:
            begin
                c_we = 1'b1;
                state_next = ST_FETCH_RD;
                if (k_reg + 5'd1 == nitems_reg)
                begin
                    k_next = '0;
                    c_next = c_reg + 5'd1;
                    if (c_reg + 5'd1 == corners)
                    begin
                        c_next = '0;
                        d_next = '0;
                        half_next = 4'(corners >> 1);
                        if (ndim_reg == 3'd0)
                            state_next = ST_OUT_RD;
                        else
                            state_next = ST_BL_RD;
                    end
                end
                else
                    k_next = k_reg + 5'd1;
            end
            ST_BL_RD:
            begin
                c_raddr    = {c_reg[3:0], k_reg[3:0]};
                state_next = ST_BL_MUL1;
            end
            ST_BL_MUL1:
            begin
                mul_b      = ONE_Q16 - factor_reg[dl];
                prod_next  = mul_p;
                c_raddr    = {c_reg[3:0] + half_reg, k_reg[3:0]};
                state_next = ST_BL_MUL2;
            end
            ST_BL_MUL2:
            begin
                mul_b      = factor_reg[dl];
                acc_next   = prod_reg + 50'sd32768;
                prod_next  = mul_p;
                state_next = ST_BL_WR;
            end
            ST_BL_WR:
            begin
                c_we    = 1'b1;
                c_wdata = bsum[47:16];
                state_next = ST_BL_RD;
                if (k_reg + 5'd1 == nitems_reg)
                begin
                    k_next = '0;
                    c_next = c_reg + 5'd1;
                    if (c_reg[3:0] + 4'd1 == half_reg)
                    begin
                        c_next    = '0;
                        d_next    = d_reg + 3'd1;
                        half_next = half_reg >> 1;
                        if (d_reg + 3'd1 == ndim_reg)
                            state_next = ST_OUT_RD;
                    end
                end
                else
                    k_next = k_reg + 5'd1;
            end
            ST_OUT_RD:
            begin
                c_raddr    = {4'd0, k_reg[3:0]};
                state_next = ST_OUT_LOAD;
            end
            ST_OUT_LOAD:
            begin
                result_next     = c_rd;
                item_index_next = k_reg[3:0];
                last_next       = (k_reg + 5'd1 == nitems_reg);
                oor_next        = flag_reg;
                out_valid_next  = 1'b1;
                state_next      = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        k_next     = k_reg + 5'd1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // next dimension, or on to the corner fetch
        if (adv)
        begin
            d_next = d_reg + 3'd1;
            if (d_reg + 3'd1 == ndim_reg)
            begin
                c_next     = '0;
                k_next     = '0;
                state_next = ST_FETCH_RD;
            end
            else
                state_next = ST_DIM;
        end
    end

    assign out_valid    = out_valid_reg;
    assign item_index   = item_index_reg;
    assign result_value = result_reg;
    assign last_item    = last_reg;
    assign out_of_range = oor_reg;

endmodule

[bench/mgi_checker.sv]
// Checker for the grid interpolator: tracks config, predicts query results, compares outputs.
module mgi_checker
    import mgi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [4:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         action,
    input  logic [1:0]         dim,
    input  logic [2:0]         point_index,
    input  logic [15:0]        table_address,
    input  logic signed [31:0] write_value,
    input  logic signed [31:0] coord_0,
    input  logic signed [31:0] coord_1,
    input  logic signed [31:0] coord_2,
    input  logic signed [31:0] coord_3,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [3:0]         item_index,
    input  logic signed [31:0] result_value,
    input  logic               last_item,
    input  logic               out_of_range,
    output int                 fail_count,
    output int                 pending,
    output int                 results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [3:0]         idx;
        logic signed [31:0] val;
        logic               last;
        logic               oor;
    } interp_result_t;

    interp_result_t     result_queue[$];
    logic [2:0]         reg_dims;
    logic [4:0]         reg_items;
    logic [3:0]         reg_pts[MAX_DIMS];
    logic signed [31:0] grid_mem[MAX_DIMS*MAX_POINTS];
    logic signed [31:0] node_mem[1<<16];

    function automatic logic signed [31:0] lerp_q16(input logic signed [31:0] lhs,
                                                  input logic signed [31:0] rhs,
                                                  input longint f);
        longint sum;
        sum = longint'(lhs) * (65536 - f) + longint'(rhs) * f;
        sum = (sum + 32768) >>> 16;
        return sum[31:0];
    endfunction

    task automatic predict_query(input logic signed [31:0] crd[MAX_DIMS]);
        int                 ndim, nit, n, u, a;
        int                 lower[MAX_DIMS];
        int                 idx[MAX_DIMS];
        longint             factor[MAX_DIMS];
        longint             num, den;
        logic               flag;
        logic signed [31:0] x;
        logic signed [31:0] cbuf[16][16];
        int                 active, half;
        interp_result_t     r;
        ndim = (reg_dims > MAX_DIMS) ? MAX_DIMS : int'(reg_dims);
        nit = (reg_items < 1) ? 1 : ((reg_items > MAX_ITEMS) ? MAX_ITEMS : int'(reg_items));
        flag = 1'b0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            lower[d] = 0;
            factor[d] = 0;
        end
        for (int d = 0; d < ndim; d++)
        begin
            n = (reg_pts[d] < 2) ? 2 : ((reg_pts[d] > MAX_POINTS) ? MAX_POINTS : int'(reg_pts[d]));
            x = crd[d];
            if (x == grid_mem[d*MAX_POINTS + n - 1])
            begin
                lower[d] = n - 2;
                factor[d] = 65536;
                continue;
            end
            u = n;
            for (int i = 0; i < n; i++)
            begin
                if (grid_mem[d*MAX_POINTS + i] > x)
                begin
                    u = i;
                    break;
                end
            end
            if (u == n)
            begin
                lower[d] = n - 2;
                factor[d] = 65536;
                flag = 1'b1;
            end
            else if (u == 0)
            begin
                flag = 1'b1;
            end
            else
            begin
                lower[d] = u - 1;
                num = longint'(x) - longint'(grid_mem[d*MAX_POINTS + u - 1]);
                den = longint'(grid_mem[d*MAX_POINTS + u]) - longint'(grid_mem[d*MAX_POINTS + u - 1]);
                factor[d] = (num <<< 16) / den;
            end
        end
        // corner c: bit (ndim-1-d) selects upper node in dimension d
        for (int c = 0; c < (1 << ndim); c++)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
                idx[d] = lower[d];
            for (int d = 0; d < ndim; d++)
                idx[d] += (c >> (ndim - 1 - d)) & 1;
            for (int k = 0; k < nit; k++)
            begin
                a = k;
                for (int d = 0; d < MAX_DIMS; d++)
                    a |= (idx[d] & 7) << (ITEM_BITS + NODE_BITS*(MAX_DIMS - 1 - d));
                cbuf[c][k] = node_mem[a & 16'hffff];
            end
        end
        active = 1 << ndim;
        for (int d = 0; d < ndim; d++)
        begin
            half = active / 2;
            for (int c = 0; c < half; c++)
                for (int k = 0; k < nit; k++)
                    cbuf[c][k] = lerp_q16(cbuf[c][k], cbuf[c + half][k], factor[d]);
            active = half;
        end
        for (int k = 0; k < nit; k++)
        begin
            r.idx = k[3:0];
            r.val = cbuf[0][k];
            r.last = (k == nit - 1);
            r.oor = flag;
            result_queue.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        interp_result_t exp_r;
        logic signed [31:0] crd[MAX_DIMS];
        if (!rst_n)
        begin
            reg_dims <= 3'd1;
            reg_items <= 5'd1;
            for (int d = 0; d < MAX_DIMS; d++)
                reg_pts[d] <= 4'd2;
            fail_count <= 0;
            results_seen <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DIMS:  reg_dims <= cfg_data[2:0];
                    REG_ITEMS: reg_items <= cfg_data;
                    REG_PTS0:  reg_pts[0] <= cfg_data[3:0];
                    REG_PTS1:  reg_pts[1] <= cfg_data[3:0];
                    REG_PTS2:  reg_pts[2] <= cfg_data[3:0];
                    REG_PTS3:  reg_pts[3] <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                case (action)
                    ACT_GRID:  grid_mem[dim*MAX_POINTS + point_index] = write_value;
                    ACT_TABLE: node_mem[table_address] = write_value;
                    ACT_QUERY:
                    begin
                        crd[0] = coord_0;
                        crd[1] = coord_1;
                        crd[2] = coord_2;
                        crd[3] = coord_3;
                        predict_query(crd);
                    end
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (result_queue.size() == 0)
                begin
                    $display("%0t: unexpected result idx %0d value %0d", $time,
                             item_index, result_value);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = result_queue.pop_front();
                    if (exp_r.idx !== item_index || exp_r.val !== result_value ||
                        exp_r.last !== last_item || exp_r.oor !== out_of_range)
                    begin
                        $display("%0t: mismatch expected idx %0d val %0d last %0b oor %0b",
                                 $time, exp_r.idx, exp_r.val, exp_r.last, exp_r.oor);
                        $display("%0t:            actual idx %0d val %0d last %0b oor %0b",
                                 $time, item_index, result_value, last_item, out_of_range);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= result_queue.size();
        end
    end
endmodule

[bench/tb_top.sv]
// Testbench top: clock, reset, stimulus for the grid interpolator and the verdict.
module tb_top;
    import mgi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [1:0]         act;
        logic [1:0]         dm;
        logic [2:0]         pt;
        logic [15:0]        addr;
        logic signed [31:0] wv;
        logic signed [31:0] crd[MAX_DIMS];
    } xact_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [4:0]         cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         action = '0;
    logic [1:0]         dim = '0;
    logic [2:0]         point_index = '0;
    logic [15:0]        table_address = '0;
    logic signed [31:0] write_value = '0;
    logic signed [31:0] coord_0 = '0, coord_1 = '0, coord_2 = '0, coord_3 = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [3:0]         item_index;
    logic signed [31:0] result_value;
    logic               last_item;
    logic               out_of_range;

    int                 fail_count, pending, results_seen;
    int                 cycles = 0;
    int                 sent = 0;
    int                 queries = 0;
    int                 tx_max = 5;
    int                 rx_max = 5;
    bit                 long_hold = 1'b0;

    logic signed [31:0] gpt[MAX_DIMS][MAX_POINTS];
    int                 neff[MAX_DIMS];
    int                 ndim_eff, nit_eff;

    multilinear_grid_interpolator_core i_dut (.*);

    mgi_checker i_checker (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // result side backpressure
    initial
    begin
        int w;
        forever
        begin
            w = (rx_max > 0) ? $urandom_range(0, rx_max) : 0;
            if (long_hold)
            begin
                w = 300;
                long_hold = 1'b0;
            end
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_item(input xact_t t);
        int gap;
        gap = (tx_max > 0) ? $urandom_range(0, tx_max) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action <= t.act;
        dim <= t.dm;
        point_index <= t.pt;
        table_address <= t.addr;
        write_value <= t.wv;
        coord_0 <= t.crd[0];
        coord_1 <= t.crd[1];
        coord_2 <= t.crd[2];
        coord_3 <= t.crd[3];
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sent++;
        if (t.act == ACT_QUERY)
            queries++;
    endtask

    function automatic xact_t blank_xact(input logic [1:0] a);
        xact_t t;
        t.act = a;
        t.dm = 2'($urandom);
        t.pt = 3'($urandom);
        t.addr = 16'($urandom);
        t.wv = $urandom;
        for (int d = 0; d < MAX_DIMS; d++)
            t.crd[d] = $urandom;
        return t;
    endfunction

    task automatic query4(input logic signed [31:0] c0, c1, c2, c3);
        xact_t t;
        t = blank_xact(ACT_QUERY);
        t.crd[0] = c0;
        t.crd[1] = c1;
        t.crd[2] = c2;
        t.crd[3] = c3;
        send_item(t);
    endtask

    function automatic logic signed [31:0] pick_coord(input int d);
        int     n, i;
        longint lo, hi;
        n = neff[d];
        i = $urandom_range(0, n - 2);
        lo = gpt[d][i];
        hi = gpt[d][i + 1];
        case ($urandom_range(0, 9))
            0: return gpt[d][n - 1];
            1: return gpt[d][$urandom_range(0, n - 1)];
            2: return gpt[d][0] - $urandom_range(1, 5000);
            3: return gpt[d][n - 1] + $urandom_range(1, 5000);
            4: return $urandom;
            default:
            begin
                if (hi > lo)
                    return 32'(lo + longint'($urandom) % (hi - lo));
                return 32'(lo);
            end
        endcase
    endfunction

    // drain, then let the block settle before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (30) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [4:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic load_phase(input bit do_cfg, input logic [2:0] dims, input logic [4:0] items,
                              input logic [3:0][3:0] pts, input bit unsorted);
        xact_t  t;
        int     total, r, ix;
        logic [15:0] base;
        logic signed [31:0] v;
        settle();
        tx_max = $urandom_range(0, 1) ? 5 : 0;
        rx_max = $urandom_range(0, 1) ? 5 : 0;
        if (do_cfg)
        begin
            cfg_write(REG_DIMS, {2'b00, dims});
            cfg_write(REG_ITEMS, items);
            cfg_write(REG_PTS0, {1'b0, pts[0]});
            cfg_write(REG_PTS1, {1'b0, pts[1]});
            cfg_write(REG_PTS2, {1'b0, pts[2]});
            cfg_write(REG_PTS3, {1'b0, pts[3]});
            cfg_we <= 1'b0;
        end
        ndim_eff = (dims > MAX_DIMS) ? MAX_DIMS : int'(dims);
        nit_eff = (items < 1) ? 1 : ((items > MAX_ITEMS) ? MAX_ITEMS : int'(items));
        for (int d = 0; d < MAX_DIMS; d++)
            neff[d] = (pts[d] < 2) ? 2 : ((pts[d] > MAX_POINTS) ? MAX_POINTS : int'(pts[d]));
        for (int d = 0; d < ndim_eff; d++)
        begin
            v = $urandom_range(0, 1 << 25) - (1 << 24);
            for (int p = 0; p < neff[d]; p++)
            begin
                gpt[d][p] = v;
                t = blank_xact(ACT_GRID);
                t.dm = 2'(d);
                t.pt = 3'(p);
                t.wv = v;
                send_item(t);
                v = unsorted ? ($urandom_range(0, 1 << 25) - (1 << 24))
                             : (v + $urandom_range(1, 1 << 20));
            end
        end
        total = 1;
        for (int d = 0; d < ndim_eff; d++)
            total *= neff[d];
        for (int node = 0; node < total; node++)
        begin
            r = node;
            base = '0;
            for (int d = ndim_eff - 1; d >= 0; d--)
            begin
                ix = r % neff[d];
                r = r / neff[d];
                base |= 16'(ix << (ITEM_BITS + NODE_BITS*(MAX_DIMS - 1 - d)));
            end
            for (int k = 0; k < nit_eff; k++)
            begin
                t = blank_xact(ACT_TABLE);
                t.addr = base | 16'(k);
                send_item(t);
            end
        end
    endtask

    task automatic random_queries(input int count);
        xact_t t;
        for (int q = 0; q < count; q++)
        begin
            t = blank_xact(ACT_QUERY);
            for (int d = 0; d < ndim_eff; d++)
                t.crd[d] = pick_coord(d);
            send_item(t);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: one dimension, two points, one value per node
        load_phase(1'b0, 3'd1, 5'd1, {4'd2, 4'd2, 4'd2, 4'd2}, 1'b0);
        // unused action code and a stray table write
        send_item(blank_xact(2'd3));
        send_item(blank_xact(ACT_TABLE));
        query4(gpt[0][1], 0, 0, 0);
        query4(gpt[0][0], 0, 0, 0);
        query4(gpt[0][0] - 1, 0, 0, 0);
        query4(gpt[0][1] + 1, 0, 0, 0);
        query4(gpt[0][0] + (gpt[0][1] - gpt[0][0]) / 2, 0, 0, 0);
        query4(32'sh80000000, 32'sh7fffffff, 0, 0);
        query4(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        random_queries(3);

        // zero dimensions: stored vector at node zero, value count saturates at 16
        load_phase(1'b1, 3'd0, 5'd31, {4'd2, 4'd2, 4'd2, 4'd2}, 1'b0);
        query4(0, 0, 0, 0);
        random_queries(1);

        // dimension count saturates high, value count and point counts saturate low
        load_phase(1'b1, 3'd7, 5'd0, {4'd0, 4'd1, 4'd0, 4'd1}, 1'b0);
        long_hold = 1'b1;
        random_queries(8);

        // eight points along one dimension, point count saturates
        load_phase(1'b1, 3'd1, 5'd2, {4'd2, 4'd2, 4'd2, 4'd15}, 1'b0);
        random_queries(8);

        // unsorted grid
        load_phase(1'b1, 3'd1, 5'd1, {4'd2, 4'd2, 4'd2, 4'd4}, 1'b1);
        random_queries(6);

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (100) @(posedge clk);
        $display("tb_top: %0d transactions sent (%0d queries), %0d results checked",
                 sent, queries, results_seen);
        $display("tb_top: covered 0, 1 and 4 dimensions, 1..16 values, saturated registers");
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
